// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; clock clk, reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ESW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/esw_pkg.sv
// ----------------------------------------------------------------------------
// esw_pkg
// Types and constants of the encoder speed weighted average core.
// ----------------------------------------------------------------------------
package esw_pkg;

	localparam int MAX_WINDOW = 128;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int SPEED_W    = 48;
	localparam int CNT_W      = 16;
	localparam int TICK_W     = 32;
	localparam int CPR_W      = 16;
	localparam int LEN_W      = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DEN_W      = CPR_W + TICK_W;
	localparam int ACC_W      = 72;
	localparam int DIV_CNT_W  = 7;
	localparam int DIV1_BITS  = 49;
	localparam int WT_W       = 17;
	localparam int WSUM_W     = 24;
	localparam int EXPV_W     = 31;
	localparam int QDEPTH     = 2;

	localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EXP     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CPR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

	localparam logic [CPR_W-1:0]  CPR_RESET  = 16'd1024;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 8'd100;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_EXP;

	localparam logic [15:0] RPM_SCALE = 16'd60000;
	// exp(-0.07) in Q0.30
	localparam logic [29:0] EXP_STEP  = 30'd1001150241;

	typedef struct packed {
		logic signed [CNT_W-1:0] delta;
		logic [TICK_W-1:0]       dt;
	} esw_item_t;

	typedef struct packed {
		logic                 start;
		logic [ACC_W-1:0]     num;
		logic [DEN_W-1:0]     den;
		logic [DIV_CNT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_MUL, BK_DIV1, BK_WAIT1, BK_STORE, BK_ACC,
		BK_PREP2, BK_DIV2, BK_WAIT2, BK_DONE
	} bk_state_t;

endpackage

// File: rtl/esw_front.sv
// ----------------------------------------------------------------------------
// esw_front
// Takes encoder words, forms count delta and elapsed time, queues them.
// ----------------------------------------------------------------------------
module esw_front import esw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [47:0]              s_axis_tdata,  // count_value[15:0], tick_ms[47:16]
	output logic                     q_valid,
	output esw_item_t                q_item,
	input  logic                     q_pop,
	output logic [$clog2(QDEPTH+1)-1:0] q_count
);

	localparam int PTR_W = $clog2(QDEPTH);

	logic [CNT_W-1:0]  prev_count_q;
	logic [TICK_W-1:0] prev_tick_q;
	esw_item_t         fifo_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [$clog2(QDEPTH+1)-1:0] cnt_q;

	logic              push;
	logic [CNT_W-1:0]  cnt_in, d16;
	logic [TICK_W-1:0] tick_in, dt_raw;
	esw_item_t         item_in;

	assign cnt_in  = s_axis_tdata[15:0];
	assign tick_in = s_axis_tdata[47:16];
	assign d16     = cnt_in - prev_count_q;
	assign dt_raw  = tick_in - prev_tick_q;

	always_comb begin
		item_in.delta = $signed(d16);
		item_in.dt    = (dt_raw == '0) ? TICK_W'(1) : dt_raw;
	end

	assign s_axis_tready = (cnt_q != ($clog2(QDEPTH+1))'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != '0);
	assign q_item        = fifo_q[rd_ptr_q];
	assign q_count       = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			prev_tick_q  <= '0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
		end else begin
			if (push) begin
				prev_count_q <= cnt_in;
				prev_tick_q  <= tick_in;
				wr_ptr_q     <= (wr_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop && q_valid)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !(q_pop && q_valid))
				cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop && q_valid)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item_in;
	end

endmodule

// File: rtl/esw_div.sv
// ----------------------------------------------------------------------------
// esw_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module esw_div import esw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DEN_W:0]       rem_q;
	logic [ACC_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[ACC_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W:0] : rem_sh;
			num_q <= {num_q[ACC_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

// File: rtl/esw_back.sv
// ----------------------------------------------------------------------------
// esw_back
// Speed computation, speed window memory, weighted sum and final average.
// ----------------------------------------------------------------------------
module esw_back import esw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  esw_item_t          q_item,
	output logic               q_pop,
	input  logic [CPR_W-1:0]   cpr,
	input  logic [LEN_W-1:0]   win_len,
	input  logic [MODE_W-1:0]  mode,
	output div_req_t           div_req,
	input  div_rsp_t           div_rsp,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [SPEED_W-1:0] m_axis_tdata   // rpm_avg[47:0]
);

	localparam logic signed [ACC_W:0] SPD_HI =
		{{(ACC_W-SPEED_W+2){1'b0}}, {(SPEED_W-1){1'b1}}};
	localparam logic signed [ACC_W:0] SPD_LO = ~SPD_HI;

	bk_state_t state_q, state_d;

	logic signed [CNT_W-1:0] delta_q;
	logic [TICK_W-1:0]       dt_q;
	logic [31:0]             magp_q;
	logic [DEN_W-1:0]        den_q;
	logic [SPEED_W-1:0]      speed_q;
	logic [IDX_W-1:0]        wr_idx_q, rd_ptr_q;
	logic [LEN_W-1:0]        a_q;
	logic [EXPV_W-1:0]       v_q;
	logic [WSUM_W-1:0]       wsum_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]        mag2_q;
	logic                    neg2_q;
	logic [SPEED_W-1:0]      res_q;
	logic                    out_vld_q;
	logic [SPEED_W-1:0]      out_data_q;

	logic [SPEED_W-1:0]      win_mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]   win_vld_q;
	logic [SPEED_W-1:0]      rdata_s1;
	logic                    rvld_s1, vld_s1, vld_s2;
	logic [WT_W-1:0]         w_s1;
	logic signed [SPEED_W+WT_W:0] prod_s2;

	logic                 issue, div_start, load_out, out_free;
	logic [LEN_W-1:0]     len_eff;
	logic [CPR_W-1:0]     cpr_eff;
	logic [CNT_W-1:0]     abs_d;
	logic [DIV1_BITS-1:0] num1;
	logic [WT_W-1:0]      w;
	logic [EXPV_W-1:0]    v_rnd;
	logic [60:0]          v_prod;
	logic signed [ACC_W-1:0] nsum;
	logic [SPEED_W-1:0]   q1;
	logic signed [ACC_W:0] res_x;
	logic signed [SPEED_W-1:0] speed_rd;

	assign cpr_eff = (cpr == '0) ? CPR_W'(1) : cpr;
	always_comb begin
		if (win_len == '0)
			len_eff = LEN_W'(1);
		else if (win_len > LEN_W'(MAX_WINDOW))
			len_eff = LEN_W'(MAX_WINDOW);
		else
			len_eff = win_len;
	end

	assign abs_d = delta_q[CNT_W-1] ? -delta_q : delta_q;
	// (|delta|*60000 << 16) + den/2, both under 2^48
	assign num1  = {1'b0, magp_q, 16'b0} + {1'b0, den_q >> 1};
	assign q1    = div_rsp.quo[SPEED_W-1:0];

	// weight of the entry being issued
	assign v_rnd  = v_q + EXPV_W'(1 << 13);
	assign v_prod = v_q * EXP_STEP + 61'(1 << 29);
	always_comb begin
		unique case (mode)
			MODE_LINEAR: w = WT_W'(len_eff - a_q);
			MODE_EXP:    w = v_rnd[30:14];
			default:     w = WT_W'(1);
		endcase
	end

	assign nsum  = acc_q + ACC_W'(wsum_q >> 1);
	assign res_x = neg2_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
	assign speed_rd = rvld_s1 ? $signed(rdata_s1) : '0;
	assign out_free = !out_vld_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid) state_d = BK_MUL;
			BK_MUL:   state_d = BK_DIV1;
			BK_DIV1:  state_d = BK_WAIT1;
			BK_WAIT1: if (div_rsp.done) state_d = BK_STORE;
			BK_STORE: state_d = BK_ACC;
			BK_ACC:   if (a_q == len_eff && !vld_s1 && !vld_s2) state_d = BK_PREP2;
			BK_PREP2: state_d = BK_DIV2;
			BK_DIV2:  state_d = BK_WAIT2;
			BK_WAIT2: if (div_rsp.done) state_d = BK_DONE;
			BK_DONE:  if (out_free) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_IDLE: q_pop     = q_valid;
			BK_DIV1: div_start = 1'b1;
			BK_ACC:  issue     = (a_q != len_eff);
			BK_DIV2: div_start = 1'b1;
			BK_DONE: load_out  = out_free;
			default: ;
		endcase
	end

	always_comb begin
		div_req.start = div_start;
		if (state_q == BK_DIV1) begin
			div_req.num   = {num1, {(ACC_W-DIV1_BITS){1'b0}}};
			div_req.den   = den_q;
			div_req.iters = DIV_CNT_W'(DIV1_BITS);
		end else begin
			div_req.num   = mag2_q;
			div_req.den   = DEN_W'(wsum_q);
			div_req.iters = DIV_CNT_W'(ACC_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			wr_idx_q  <= '0;
			win_vld_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			vld_s2  <= vld_s1;
			if (state_q == BK_STORE) begin
				wr_idx_q            <= wr_idx_q + 1'b1;
				win_vld_q[wr_idx_q] <= 1'b1;
			end
			if (load_out)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			delta_q <= q_item.delta;
			dt_q    <= q_item.dt;
		end
		if (state_q == BK_MUL) begin
			magp_q <= abs_d * RPM_SCALE;
			den_q  <= dt_q * cpr_eff;
		end
		if (state_q == BK_WAIT1 && div_rsp.done)
			speed_q <= delta_q[CNT_W-1] ? -q1 : q1;
		if (state_q == BK_STORE) begin
			win_mem[wr_idx_q] <= speed_q;
			rd_ptr_q <= wr_idx_q;
			a_q      <= '0;
			v_q      <= EXPV_W'(1 << 30);
			wsum_q   <= '0;
			acc_q    <= '0;
		end
		if (issue) begin
			rdata_s1 <= win_mem[rd_ptr_q];
			rvld_s1  <= win_vld_q[rd_ptr_q];
			w_s1     <= w;
			rd_ptr_q <= rd_ptr_q - 1'b1;
			a_q      <= a_q + 1'b1;
			v_q      <= v_prod[60:30];
			wsum_q   <= wsum_q + WSUM_W'(w);
		end
		if (vld_s1)
			prod_s2 <= speed_rd * $signed({1'b0, w_s1});
		if (vld_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
		if (state_q == BK_PREP2) begin
			// floor division of a negative sum via the magnitude rounded up
			neg2_q <= nsum[ACC_W-1];
			mag2_q <= nsum[ACC_W-1] ? (-nsum + ACC_W'(wsum_q) - ACC_W'(1)) : nsum;
		end
		if (state_q == BK_WAIT2 && div_rsp.done) begin
			if (res_x > SPD_HI)
				res_q <= SPD_HI[SPEED_W-1:0];
			else if (res_x < SPD_LO)
				res_q <= SPD_LO[SPEED_W-1:0];
			else
				res_q <= res_x[SPEED_W-1:0];
		end
		if (load_out)
			out_data_q <= res_q;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/encoder_speed_weighted_average_core.sv
// ----------------------------------------------------------------------------
// encoder_speed_weighted_average_core
// Encoder speed in RPM (Q31.16) with a weighted moving average window.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one word per sample: encoder count and millisecond tick.
//  m_axis returns one word per sample: averaged speed rpm_avg, signed Q31.16.
//  cfg_we/cfg_idx/cfg_wdata write the counts per revolution (0), window_len
//  (1) and weight_mode (2); write only while no sample is in flight.
//  Each word goes through the speed division in the shared bit-serial divider,
//  a multiply-accumulate over window_len entries followed by a drain of its
//  pipeline, the average division in the same divider, and control steps in
//  between. A new word starts right after the previous one leaves.
//  One word is worked on at a time; a two-entry queue takes new words while
//  the back end is busy, and the output register holds a result while
//  m_axis_tready is low so the back end can start the next word.
//  Reset clears the window to zero speeds, the previous count and tick, the
//  queue and the registers to their defaults (1024, 100, exponential).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module encoder_speed_weighted_average_core import esw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [47:0]           s_axis_tdata,  // count_value[15:0], tick_ms[47:16]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [SPEED_W-1:0]    m_axis_tdata,  // rpm_avg[47:0]
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [CPR_W-1:0]  cpr_q;
	logic [LEN_W-1:0]  len_q;
	logic [MODE_W-1:0] mode_q;

	logic       q_valid, q_pop;
	esw_item_t  q_item;
	logic [$clog2(QDEPTH+1)-1:0] q_count;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q  <= CPR_RESET;
			len_q  <= LEN_RESET;
			mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CPR:  cpr_q  <= cfg_wdata[CPR_W-1:0];
				REG_LEN:  len_q  <= cfg_wdata[LEN_W-1:0];
				REG_MODE: mode_q <= cfg_wdata[MODE_W-1:0];
				default:  ;
			endcase
		end
	end

	esw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.q_count       (q_count)
	);

	esw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	esw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.cpr           (cpr_q),
		.win_len       (len_q),
		.mode          (mode_q),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	`ESW_ASSERT_IMP(a_div_no_restart, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`ESW_ASSERT_NXT(a_div_runs, div_req.start, div_rsp.busy, "divider did not start")
	`ESW_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= ($clog2(QDEPTH+1))'(QDEPTH), "queue overrun")
	`ESW_ASSERT_IMP(a_pop_nonempty, q_pop, q_count != '0, "pop from empty queue")

endmodule

// File: bench/esw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esw_checker
// Watches the sample, speed and config channels of the speed averaging core,
// predicts each averaged speed word and compares it with the one returned.
// ----------------------------------------------------------------------------
module esw_checker import esw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [47:0]           s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [SPEED_W-1:0]    m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    errors,
	output int                    pending,
	output int                    speeds_seen
);

	localparam longint SPD_HI = (64'sd1 <<< (SPEED_W-1)) - 1;
	localparam longint SPD_LO = -SPD_HI - 1;

	logic [CPR_W-1:0]    cpr;
	logic [LEN_W-1:0]    win_len;
	logic [MODE_W-1:0]   mode;
	longint              window_spd [MAX_WINDOW];
	logic [IDX_W-1:0]    next_slot;
	logic [CNT_W-1:0]    prev_cnt;
	logic [TICK_W-1:0]   last_tick;
	logic [SPEED_W-1:0]  speed_expected_q [$];

	function automatic longint clamp_spd(input logic signed [95:0] v);
		if (v > SPD_HI) return SPD_HI;
		if (v < SPD_LO) return SPD_LO;
		return longint'(v);
	endfunction

	// updates the window and history, returns the averaged speed
	function automatic logic [SPEED_W-1:0] predict_speed(input logic [CNT_W-1:0] cnt,
			input logic [TICK_W-1:0] tick);
		logic [CNT_W-1:0]         d16;
		logic [TICK_W-1:0]        dt32;
		longint                   delta, mag, dt, den, q, spd, w, wsum, v;
		int                       len, a;
		logic signed [95:0]       acc, n, quo;
		d16 = cnt - prev_cnt;
		delta = $signed(d16);
		// elapsed time wraps at 32 bits
		dt32 = tick - last_tick;
		dt = longint'(dt32);
		if (dt == 0) dt = 1;
		den = dt * ((cpr == 0) ? 1 : longint'(cpr));
		mag = (delta < 0 ? -delta : delta) * 60000 * 65536;
		q = (mag + den / 2) / den;
		spd = clamp_spd(delta < 0 ? -q : q);
		window_spd[next_slot] = spd;
		next_slot = next_slot + 1'b1;
		prev_cnt = cnt;
		last_tick = tick;

		len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW ? MAX_WINDOW : int'(win_len));
		acc = 0;
		wsum = 0;
		v = 64'd1 << 30;
		for (a = 0; a < len; a++) begin
			if (mode == MODE_LINEAR) begin
				w = len - a;
			end else if (mode == MODE_EXP) begin
				w = (v + (64'd1 << 13)) >>> 14;
				v = (v * 1001150241 + (64'd1 << 29)) >>> 30;
			end else begin
				w = 1;
			end
			acc += 96'(signed'(window_spd[(next_slot - 1 - a) % MAX_WINDOW])) * 96'(w);
			wsum += w;
		end
		n = acc + 96'(wsum / 2);
		if (n >= 0) quo = n / 96'(wsum);
		else quo = -((-n + 96'(wsum) - 1) / 96'(wsum));
		return SPEED_W'(clamp_spd(quo));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr <= CPR_RESET;
			win_len <= LEN_RESET;
			mode <= MODE_RESET;
			foreach (window_spd[i]) window_spd[i] = 0;
			next_slot <= '0;
			prev_cnt <= '0;
			last_tick <= '0;
			errors <= 0;
			pending <= 0;
			speeds_seen <= 0;
			speed_expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CPR:  cpr <= cfg_wdata[CPR_W-1:0];
					REG_LEN:  win_len <= cfg_wdata[LEN_W-1:0];
					REG_MODE: mode <= cfg_wdata[MODE_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				speed_expected_q.push_back(predict_speed(s_axis_tdata[15:0], s_axis_tdata[47:16]));
			if (m_axis_tvalid && m_axis_tready) begin
				speeds_seen <= speeds_seen + 1;
				if (speed_expected_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("checker: unexpected word %h", m_axis_tdata);
				end else begin
					if (m_axis_tdata !== speed_expected_q[0]) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("checker: rpm_avg expected %h got %h",
								speed_expected_q[0], m_axis_tdata);
					end
					void'(speed_expected_q.pop_front());
				end
			end
			pending <= speed_expected_q.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives encoder samples and config writes into the speed averaging core,
// with random stalls on both streams; the checker predicts every word.
// ----------------------------------------------------------------------------
module tb import esw_pkg::*;;

	localparam int STALL_LIMIT = 40000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [47:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [SPEED_W-1:0]    m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    errors, pending, speeds_seen;
	bit                    gaps_on;
	int                    stall_cnt;
	int                    words_sent;
	logic [CNT_W-1:0]      cur_count;
	logic [TICK_W-1:0]     cur_tick;

	encoder_speed_weighted_average_core i_dut (.*);

	esw_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		m_axis_tready <= gaps_on ? ($urandom_range(99) >= 37) : 1'b1;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic send_word(input logic [CNT_W-1:0] cnt, input logic [TICK_W-1:0] tick);
		if (gaps_on && $urandom_range(99) < 37) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tick, cnt};
		cur_count = cnt;
		cur_tick = tick;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
	endtask

	// drain everything, then write one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_motion(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: send_word(CNT_W'($urandom), $urandom);
				1: send_word(cur_count + CNT_W'($urandom_range(65535)), cur_tick);
				2: send_word(cur_count - CNT_W'($urandom_range(3000)),
					cur_tick + $urandom_range(20, 1));
				default: send_word(cur_count + CNT_W'($urandom_range(3000)),
					cur_tick + $urandom_range(50, 1));
			endcase
		end
	endtask

	initial begin
		int ph;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_wdata = '0;
		gaps_on = 1;
		stall_cnt = 0;
		words_sent = 0;
		cur_count = '0;
		cur_tick = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// defaults first: big positive, big negative delta, zero elapsed time
		send_word(16'h7fff, 32'd1);
		send_word(16'hffff, 32'd1);
		send_word(16'h8000, 32'hffff_ffff);
		send_word(16'h0000, 32'h0000_0002);
		write_reg(REG_CPR, 16'd0);
		write_reg(REG_LEN, 16'd0);
		write_reg(REG_MODE, 16'(MODE_UNIFORM));
		send_word(16'h7fff, 32'd3);
		send_word(16'h7fff, 32'd3);
		write_reg(REG_LEN, 16'd255);
		write_reg(REG_MODE, 16'(MODE_LINEAR));
		send_word(16'hffff, 32'h8000_0000);
		send_word(16'h7fff, 32'h8000_0001);
		write_reg(REG_MODE, 16'd3);
		write_reg(REG_CPR, 16'hffff);
		write_reg(2'd3, 16'hffff);
		send_word(16'h1234, 32'h8000_0001);
		write_reg(REG_LEN, 16'd128);
		write_reg(REG_MODE, 16'(MODE_EXP));
		write_reg(REG_CPR, 16'd1);
		send_word(16'h9234, 32'h8000_0002);
		send_word(16'h1234, 32'h8000_0003);
		write_reg(REG_LEN, 16'd1);
		send_word(16'h0001, 32'h7fff_ffff);

		for (ph = 0; ph < 9; ph++) begin
			gaps_on = (ph != 4);
			write_reg(REG_CPR, (ph % 3 == 0) ? 16'($urandom_range(65535))
				: 16'($urandom_range(4096)));
			write_reg(REG_LEN, (ph == 1) ? 16'd128 : (ph == 2) ? 16'd1
				: 16'($urandom_range(255)));
			write_reg(REG_MODE, 16'(ph % 4));
			send_motion(120);
		end
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("tb: %0d samples sent, %0d speed words checked", words_sent, speeds_seen);
		$display("tb: all weight modes, window lengths 0..255, cpr 0..65535, stalls");
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/esw_pkg.sv
rtl/esw_front.sv
rtl/esw_div.sv
rtl/esw_back.sv
rtl/encoder_speed_weighted_average_core.sv
bench/esw_checker.sv
bench/tb.sv
